// File: hdl/rc6_pkg.sv
// Shared constants, types and helper functions of the RC6 block encryption core.
`timescale 1ns / 1ps
package rc6_pkg;

    localparam int WORD_W     = 32;
    localparam int ROUNDS     = 20;
    localparam int KEY_WORDS  = 8;
    localparam int TABLE_SIZE = 2 * ROUNDS + 4;
    localparam int MIX_STEPS  = 3 * TABLE_SIZE;
    localparam int INIT_LEN   = (TABLE_SIZE > KEY_WORDS) ? TABLE_SIZE : KEY_WORDS;

    localparam int KI_W      = $clog2(TABLE_SIZE);
    localparam int LI_W      = $clog2(KEY_WORDS);
    localparam int STEP_W    = $clog2(MIX_STEPS);
    localparam int INIT_W    = $clog2(INIT_LEN);
    localparam int CFG_IDX_W = 4;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E3779B9;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key_words;

    // Write and read request of the key schedule toward the round-key table.
    typedef struct packed {
        logic              we;
        logic [KI_W-1:0]   waddr;
        logic [WORD_W-1:0] wdata;
        logic [KI_W-1:0]   raddr;
    } t_rk_req;

    // Left rotation of a word; only the low five bits of the amount count.
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] n);
        rotl32 = (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

endpackage

// File: hdl/rc6_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module rc6_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: hdl/rc6_keysched.sv
// Key expansion sequencer: fills the round-key table and mixes it with the key words.
`timescale 1ns / 1ps
module rc6_keysched (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_key_wr,
    input  rc6_pkg::t_key_words i_key,
    input  logic [31:0]         i_rk_rdata,
    output rc6_pkg::t_rk_req    o_req,
    output logic                o_ready
);
    import rc6_pkg::*;

    typedef enum logic [2:0] {
        KS_IDLE = 3'b001,
        KS_INIT = 3'b010,
        KS_MIX  = 3'b100
    } t_ks_state;

    t_ks_state         r_state;
    logic              r_dirty;
    logic [INIT_W-1:0] r_cnt;
    logic [STEP_W-1:0] r_step;
    logic [KI_W-1:0]   r_ti;
    logic [LI_W-1:0]   r_li;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_t;
    logic [WORD_W-1:0] r_mix [KEY_WORDS];

    logic [KI_W-1:0]   n_ti;
    logic [WORD_W-1:0] n_a;
    logic [WORD_W-1:0] n_b;
    logic [WORD_W-1:0] w_ab;
    logic              w_init_last;
    logic              w_mix_last;

    assign n_ti        = (r_ti == KI_W'(TABLE_SIZE - 1)) ? '0 : r_ti + KI_W'(1);
    assign n_a         = rotl32(i_rk_rdata + r_a + r_b, 5'd3);
    assign w_ab        = n_a + r_b;
    assign n_b         = rotl32(r_mix[r_li] + w_ab, w_ab[4:0]);
    assign w_init_last = r_cnt == INIT_W'(INIT_LEN - 1);
    assign w_mix_last  = r_step == STEP_W'(MIX_STEPS - 1);

    always_comb begin
        o_req = '0;
        case (r_state)
            KS_INIT: begin
                o_req.we    = r_cnt < INIT_W'(TABLE_SIZE);
                o_req.waddr = KI_W'(r_cnt);
                o_req.wdata = r_t;
                o_req.raddr = '0;
            end
            KS_MIX: begin
                // The next step's entry is fetched while this step writes back;
                // consecutive steps never touch the same entry.
                o_req.we    = 1'b1;
                o_req.waddr = r_ti;
                o_req.wdata = n_a;
                o_req.raddr = n_ti;
            end
            default: begin
                o_req = '0;
            end
        endcase
    end

    assign o_ready = (r_state == KS_IDLE) && !r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_IDLE;
            r_dirty <= 1'b1;
        end else begin
            case (r_state)
                KS_IDLE: begin
                    // A key write while idle marks the schedule stale; a
                    // stale schedule starts over and stays stale only if
                    // another write lands in the same cycle.
                    r_dirty <= i_key_wr;
                    if (r_dirty) begin
                        r_state <= KS_INIT;
                    end
                end
                KS_INIT: begin
                    r_dirty <= r_dirty || i_key_wr;
                    if (w_init_last) begin
                        r_state <= KS_MIX;
                    end
                end
                KS_MIX: begin
                    r_dirty <= r_dirty || i_key_wr;
                    if (w_mix_last) begin
                        r_state <= KS_IDLE;
                    end
                end
                default: begin
                    r_state <= KS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            KS_IDLE: begin
                r_cnt <= '0;
                r_t   <= MAGIC_P;
            end
            KS_INIT: begin
                r_cnt <= r_cnt + INIT_W'(1);
                r_t   <= r_t + MAGIC_Q;
                if (r_cnt < INIT_W'(KEY_WORDS)) begin
                    r_mix[LI_W'(r_cnt)] <= i_key[LI_W'(r_cnt)];
                end
                r_step <= '0;
                r_ti   <= '0;
                r_li   <= '0;
                r_a    <= '0;
                r_b    <= '0;
            end
            KS_MIX: begin
                r_step      <= r_step + STEP_W'(1);
                r_ti        <= n_ti;
                r_li        <= r_li + LI_W'(1);
                r_a         <= n_a;
                r_b         <= n_b;
                r_mix[r_li] <= n_b;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    a_mix_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KS_MIX) |-> (o_req.raddr != o_req.waddr))
        else $error("key mix reads the entry it writes");

    a_mix_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KS_MIX && w_mix_last) |->
            (r_ti == KI_W'((MIX_STEPS - 1) % TABLE_SIZE) &&
             r_li == LI_W'((MIX_STEPS - 1) % KEY_WORDS)))
        else $error("key mix indexes out of step at the last mixing step");

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_req.we)
        else $error("round-key table written while the schedule is ready");

endmodule

// File: hdl/rc6_round.sv
// Round sequencer: whitening and all rounds of one block on a shared round unit.
`timescale 1ns / 1ps
module rc6_round (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_key_ok,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [31:0]              i_plain_a,
    input  logic [31:0]              i_plain_b,
    input  logic [31:0]              i_plain_c,
    input  logic [31:0]              i_plain_d,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [31:0]              o_cipher_a,
    output logic [31:0]              o_cipher_b,
    output logic [31:0]              o_cipher_c,
    output logic [31:0]              o_cipher_d,
    output logic [rc6_pkg::KI_W-1:0] o_rk_raddr_a,
    output logic [rc6_pkg::KI_W-1:0] o_rk_raddr_b,
    input  logic [31:0]              i_rk_rdata_a,
    input  logic [31:0]              i_rk_rdata_b
);
    import rc6_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PRE  = 4'b0010,
        S_RND  = 4'b0100,
        S_POST = 4'b1000
    } t_rnd_state;

    t_rnd_state        r_state;
    logic              r_out_valid;
    logic [KI_W-1:0]   r_ki;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_c;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W-1:0] r_out_a;
    logic [WORD_W-1:0] r_out_b;
    logic [WORD_W-1:0] r_out_c;
    logic [WORD_W-1:0] r_out_d;

    logic              w_accept;
    logic              w_out_free;
    logic              w_last;
    logic [WORD_W-1:0] w_qb;
    logic [WORD_W-1:0] w_qd;
    logic [WORD_W-1:0] w_x;
    logic [WORD_W-1:0] w_y;
    logic [WORD_W-1:0] n_a;
    logic [WORD_W-1:0] n_c;

    assign o_in_stall = !((r_state == S_IDLE) && i_key_ok);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = r_ki == KI_W'(TABLE_SIZE - 4);

    // Quadratic terms X*(2X+1), low word only.
    assign w_qb = r_b * {r_b[WORD_W-2:0], 1'b1};
    assign w_qd = r_d * {r_d[WORD_W-2:0], 1'b1};
    assign w_x  = rotl32(w_qb, 5'd5);
    assign w_y  = rotl32(w_qd, 5'd5);
    assign n_a  = rotl32(r_a ^ w_x, w_y[4:0]) + i_rk_rdata_a;
    assign n_c  = rotl32(r_c ^ w_y, w_x[4:0]) + i_rk_rdata_b;

    // Keys for the next step are fetched ahead, as the table reads are registered;
    // in the final state the address holds so the whitening keys survive a stall.
    always_comb begin
        case (r_state)
            S_PRE, S_RND: begin
                o_rk_raddr_a = r_ki + KI_W'(2);
                o_rk_raddr_b = r_ki + KI_W'(3);
            end
            S_POST: begin
                o_rk_raddr_a = r_ki;
                o_rk_raddr_b = r_ki + KI_W'(1);
            end
            default: begin
                o_rk_raddr_a = '0;
                o_rk_raddr_b = KI_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A new result may replace the one taken in the same cycle.
            if ((r_state == S_POST) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    if (w_last) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_a  <= i_plain_a;
                    r_b  <= i_plain_b;
                    r_c  <= i_plain_c;
                    r_d  <= i_plain_d;
                    r_ki <= '0;
                end
            end
            S_PRE: begin
                r_b  <= r_b + i_rk_rdata_a;
                r_d  <= r_d + i_rk_rdata_b;
                r_ki <= r_ki + KI_W'(2);
            end
            S_RND: begin
                r_a  <= r_b;
                r_b  <= n_c;
                r_c  <= r_d;
                r_d  <= n_a;
                r_ki <= r_ki + KI_W'(2);
            end
            S_POST: begin
                if (w_out_free) begin
                    r_out_a <= r_a + i_rk_rdata_a;
                    r_out_b <= r_b;
                    r_out_c <= r_c + i_rk_rdata_b;
                    r_out_d <= r_d;
                end
            end
            default: begin
                r_ki <= '0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_cipher_a  = r_out_a;
    assign o_cipher_b  = r_out_b;
    assign o_cipher_c  = r_out_c;
    assign o_cipher_d  = r_out_d;

    a_result_from_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_POST))
        else $error("result beat raised outside the whitening state");

    a_post_key_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST) |-> (r_ki == KI_W'(TABLE_SIZE - 2)))
        else $error("round count slipped before output whitening");

endmodule

// File: hdl/rc6_block_encrypt.sv
// Top level of the RC6-32/20/32 block encryption core with a cached key schedule.
//
//   Channel  Direction  Handshake                  Payload
//   -------  ---------  -------------------------  ---------------------------------
//   in       sink       i_in_valid / o_in_stall    i_plain_a .. i_plain_d
//   out      source     o_out_valid / i_out_stall  o_cipher_a .. o_cipher_d
//   cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// A block runs input whitening, then the rounds one after another on the shared
// multiply-rotate-add unit, then output whitening, and an idle state takes the next
// beat; a new block is taken only once the last one is through output whitening.
// The two round keys of each step come from the round-key table RAM in one read.
// After reset and after every key write the schedule is expanded again, with the input
// stalled: an idle start, the fill of the table and key words, then the mixing passes.
// Reset is synchronous and active low. A finished result waits in the output register
// while the next block is already being worked on.
`timescale 1ns / 1ps
module rc6_block_encrypt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_plain_a,
    input  logic [31:0]                   i_plain_b,
    input  logic [31:0]                   i_plain_c,
    input  logic [31:0]                   i_plain_d,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_cipher_a,
    output logic [31:0]                   o_cipher_b,
    output logic [31:0]                   o_cipher_c,
    output logic [31:0]                   o_cipher_d,
    input  logic                          i_cfg_we,
    input  logic [rc6_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import rc6_pkg::*;

    // Key registers as written through the configuration port.
    t_key_words        r_key;
    logic              w_key_wr;

    // Key schedule side.
    t_rk_req           w_ks_req;
    logic              w_ks_ready;
    logic              w_key_ok;

    // Round-key table ports.
    logic [KI_W-1:0]   w_rnd_raddr_a;
    logic [KI_W-1:0]   w_rnd_raddr_b;
    logic [KI_W-1:0]   w_ram_raddr_a;
    logic [WORD_W-1:0] w_rk_rdata_a;
    logic [WORD_W-1:0] w_rk_rdata_b;

    // Indexes beyond the key words are ignored.
    assign w_key_wr = i_cfg_we && (i_cfg_index < CFG_IDX_W'(KEY_WORDS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (w_key_wr) begin
            r_key[i_cfg_index[LI_W-1:0]] <= i_cfg_data;
        end
    end

    // A block may start only on a finished schedule, and not in the cycle of
    // a key write that is about to mark the schedule stale.
    assign w_key_ok = w_ks_ready && !i_cfg_we;

    rc6_keysched u_keysched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_wr   (w_key_wr),
        .i_key      (r_key),
        .i_rk_rdata (w_rk_rdata_a),
        .o_req      (w_ks_req),
        .o_ready    (w_ks_ready)
    );

    // The schedule owns read port A while it runs; the round unit has the
    // table to itself otherwise.
    assign w_ram_raddr_a = w_ks_ready ? w_rnd_raddr_a : w_ks_req.raddr;

    rc6_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SIZE)
    ) u_rk_table (
        .i_clk     (i_clk),
        .i_we      (w_ks_req.we),
        .i_waddr   (w_ks_req.waddr),
        .i_wdata   (w_ks_req.wdata),
        .i_raddr_a (w_ram_raddr_a),
        .i_raddr_b (w_rnd_raddr_b),
        .o_rdata_a (w_rk_rdata_a),
        .o_rdata_b (w_rk_rdata_b)
    );

    rc6_round u_round (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_ok     (w_key_ok),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_plain_a    (i_plain_a),
        .i_plain_b    (i_plain_b),
        .i_plain_c    (i_plain_c),
        .i_plain_d    (i_plain_d),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cipher_a   (o_cipher_a),
        .o_cipher_b   (o_cipher_b),
        .o_cipher_c   (o_cipher_c),
        .o_cipher_d   (o_cipher_d),
        .o_rk_raddr_a (w_rnd_raddr_a),
        .o_rk_raddr_b (w_rnd_raddr_b),
        .i_rk_rdata_a (w_rk_rdata_a),
        .i_rk_rdata_b (w_rk_rdata_b)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the RC6-32/20/32 block encryption core.
`timescale 1ns / 1ps
module testbench;

    // Register indexes of the key words. Indexes above the last key word
    // exist on the port but address nothing.
    localparam int KEY_REG_BASE  = 0;
    localparam int KEY_REG_COUNT = rc6_pkg::KEY_WORDS;
    localparam int CFG_REG_SPAN  = 1 << rc6_pkg::CFG_IDX_W;

    localparam int RK_COUNT = rc6_pkg::TABLE_SIZE;
    localparam int N_ROUNDS = rc6_pkg::ROUNDS;

    // Length of the long output hold-off, in clock cycles.
    localparam int LONG_HOLD_CYCLES = 250;
    // Settle time after the last result before a key write or the verdict.
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_block;

    // Clock, reset and every input of the core start at known values.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    logic [31:0] plain_a     = '0;
    logic [31:0] plain_b     = '0;
    logic [31:0] plain_c     = '0;
    logic [31:0] plain_d     = '0;
    logic        out_stall   = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [rc6_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data    = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_cipher_a;
    logic [31:0] o_cipher_b;
    logic [31:0] o_cipher_c;
    logic [31:0] o_cipher_d;

    rc6_block_encrypt dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_plain_a   (plain_a),
        .i_plain_b   (plain_b),
        .i_plain_c   (plain_c),
        .i_plain_d   (plain_d),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_cipher_a  (o_cipher_a),
        .o_cipher_b  (o_cipher_b),
        .o_cipher_c  (o_cipher_c),
        .o_cipher_d  (o_cipher_d),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow copy of the key registers and the round keys expanded from them.
    // The shadow only changes while the core is idle, so the expansion is
    // redone once per key setting instead of once per block.
    logic [31:0] key_shadow [KEY_REG_COUNT];
    logic [31:0] round_keys [RK_COUNT];

    t_block plain_backlog[$];   // blocks waiting to be offered on the input
    t_block cipher_pending[$];  // predicted ciphertexts, oldest first

    int  mismatch_count = 0;
    int  blocks_checked = 0;
    int  key_settings   = 0;
    bit  quiet          = 1'b0; // no idling on either side when set

    int  in_gap_left    = 0;
    int  out_gap_left   = 0;
    int  hold_request   = 0;
    int  hold_seen      = 0;
    int  hold_left      = 0;
    logic long_hold;
    t_block next_block;
    t_block got_block;
    t_block want_block;

    assign long_hold = (hold_left > 0);

    // Left rotation; only the low five bits of the amount matter.
    function automatic logic [31:0] rol32(logic [31:0] v, logic [31:0] amount);
        int n;
        n = int'(amount[4:0]);
        if (n == 0) return v;
        return (v << n) | (v >> (32 - n));
    endfunction

    // Standard key expansion: magic-constant fill, then three passes of mixing
    // over the larger of the two arrays.
    function automatic void expand_key_schedule();
        logic [31:0] mix [KEY_REG_COUNT];
        logic [31:0] t;
        logic [31:0] sa;
        logic [31:0] sb;
        int ti;
        int li;
        t  = rc6_pkg::MAGIC_P;
        sa = '0;
        sb = '0;
        ti = 0;
        li = 0;
        for (int i = 0; i < KEY_REG_COUNT; i++) mix[i] = key_shadow[i];
        for (int i = 0; i < RK_COUNT; i++) begin
            round_keys[i] = t;
            t = t + rc6_pkg::MAGIC_Q;
        end
        for (int s = 0; s < 3 * RK_COUNT; s++) begin
            sa = rol32(round_keys[ti] + sa + sb, 3);
            round_keys[ti] = sa;
            sb = rol32(mix[li] + sa + sb, sa + sb);
            mix[li] = sb;
            ti = (ti + 1 == RK_COUNT) ? 0 : ti + 1;
            li = (li + 1) % KEY_REG_COUNT;
        end
    endfunction

    // Encryption of one block under the current round keys.
    function automatic t_block rc6_encrypt_block(t_block p);
        logic [31:0] a, b, c, d, x, y, tmp;
        t_block r;
        a = p.a;
        b = p.b + round_keys[0];
        c = p.c;
        d = p.d + round_keys[1];
        for (int k = 0; k < N_ROUNDS; k++) begin
            x   = rol32(b * ((b << 1) + 32'd1), 5);
            y   = rol32(d * ((d << 1) + 32'd1), 5);
            a   = rol32(a ^ x, y) + round_keys[2 * k + 2];
            c   = rol32(c ^ y, x) + round_keys[2 * k + 3];
            tmp = a;
            a   = b;
            b   = c;
            c   = d;
            d   = tmp;
        end
        r.a = a + round_keys[RK_COUNT - 2];
        r.b = b;
        r.c = c + round_keys[RK_COUNT - 1];
        r.d = d;
        return r;
    endfunction

    // Mostly uniform words, with a share of all-zero, all-one, one-hot and one-cold
    // words so that the degenerate products turn up in the random part too.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_block make_block(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
        t_block blk;
        blk.a = a;
        blk.b = b;
        blk.c = c;
        blk.d = d;
        return blk;
    endfunction

    // Clock with a 12 ns period.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Input driver. A beat moves when in_valid is high and the core does not
    // stall. A stalled beat is held unchanged; otherwise the next block is
    // taken from the backlog, unless a random idle burst is drawn. Each other
    // branch assigns in_valid once, so a valid that stays high never sees
    // two updates in one step.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid    <= 1'b0;
            in_gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                cipher_pending.push_back(
                    rc6_encrypt_block(make_block(plain_a, plain_b, plain_c, plain_d)));
            end
            if (in_valid && o_in_stall) begin
                // Hold the stalled beat.
            end else if (in_gap_left > 0) begin
                in_gap_left <= in_gap_left - 1;
                in_valid    <= 1'b0;
            end else if (plain_backlog.size() > 0 && !quiet && $urandom_range(0, 6) == 0) begin
                in_gap_left <= $urandom_range(0, 2);
                in_valid    <= 1'b0;
            end else if (plain_backlog.size() > 0) begin
                next_block = plain_backlog.pop_front();
                in_valid   <= 1'b1;
                plain_a    <= next_block.a;
                plain_b    <= next_block.b;
                plain_c    <= next_block.c;
                plain_d    <= next_block.d;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver. Each new request from the stimulus
    // process arms a countdown here; while it runs the output stays stalled,
    // so the core fills its output register and then stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= LONG_HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output stall: the long hold-off when armed, otherwise random bursts,
    // and none at all in the quiet part of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall    <= 1'b0;
            out_gap_left <= 0;
        end else if (long_hold) begin
            out_stall <= 1'b1;
        end else if (quiet) begin
            out_stall <= 1'b0;
        end else if (out_gap_left > 0) begin
            out_gap_left <= out_gap_left - 1;
            out_stall    <= 1'b1;
        end else if ($urandom_range(0, 6) == 0) begin
            out_gap_left <= $urandom_range(0, 2);
            out_stall    <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every accepted output beat is compared word by word
    // with the oldest predicted ciphertext.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            got_block = make_block(o_cipher_a, o_cipher_b, o_cipher_c, o_cipher_d);
            if (cipher_pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %h %h %h %h at %0t",
                             got_block.a, got_block.b, got_block.c, got_block.d, $realtime);
            end else begin
                want_block = cipher_pending.pop_front();
                blocks_checked++;
                if (got_block.a !== want_block.a || got_block.b !== want_block.b ||
                    got_block.c !== want_block.c || got_block.d !== want_block.d) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: block %0d expected %h %h %h %h got %h %h %h %h",
                                 blocks_checked, want_block.a, want_block.b, want_block.c,
                                 want_block.d, got_block.a, got_block.b, got_block.c,
                                 got_block.d);
                end
            end
        end
    end

    // One register write on the configuration port.
    task automatic write_reg(int idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= rc6_pkg::CFG_IDX_W'(idx);
        cfg_data  <= value;
        if (idx >= KEY_REG_BASE && idx < KEY_REG_BASE + KEY_REG_COUNT)
            key_shadow[idx - KEY_REG_BASE] = value;
    endtask

    // Loads a full key, optionally followed by writes to the unused indexes,
    // which must leave the key untouched. The round keys are rebuilt after.
    task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3, logic [31:0] k4, logic [31:0] k5,
                            logic [31:0] k6, logic [31:0] k7, bit poke_unused);
        logic [31:0] kw [KEY_REG_COUNT];
        kw = '{k0, k1, k2, k3, k4, k5, k6, k7};
        for (int i = 0; i < KEY_REG_COUNT; i++) write_reg(KEY_REG_BASE + i, kw[i]);
        if (poke_unused)
            for (int i = KEY_REG_BASE + KEY_REG_COUNT; i < CFG_REG_SPAN; i++)
                write_reg(i, $urandom());
        @(posedge i_clk);
        cfg_we <= 1'b0;
        expand_key_schedule();
        key_settings++;
    endtask

    // Waits until every block has been taken and every result has come back,
    // then lets the core settle before anything else touches it.
    task automatic wait_drained();
        while (plain_backlog.size() > 0 || in_valid || cipher_pending.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            plain_backlog.push_back(make_block(pick_word(), pick_word(),
                                               pick_word(), pick_word()));
    endtask

    // Blocks whose B and D cancel the whitening keys, so the first round
    // rotates by zero on both sides.
    task automatic queue_zero_rotation();
        plain_backlog.push_back(make_block(32'h0, -round_keys[0], 32'h0, -round_keys[1]));
        plain_backlog.push_back(make_block('1, -round_keys[0], '1, -round_keys[1]));
    endtask

    // Stimulus sequence.
    initial begin
        for (int i = 0; i < KEY_REG_COUNT; i++) key_shadow[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The key after reset is all zero; start with directed blocks under it.
        expand_key_schedule();
        key_settings++;
        plain_backlog.push_back(make_block('0, '0, '0, '0));
        plain_backlog.push_back(make_block('1, '1, '1, '1));
        plain_backlog.push_back(make_block(32'hAAAAAAAA, 32'h55555555,
                                           32'hAAAAAAAA, 32'h55555555));
        plain_backlog.push_back(make_block(32'h55555555, 32'hAAAAAAAA,
                                           32'h55555555, 32'hAAAAAAAA));
        plain_backlog.push_back(make_block(32'h00000001, 32'h00000000,
                                           32'h00000000, 32'h00000000));
        plain_backlog.push_back(make_block(32'h00000000, 32'h80000000,
                                           32'h00000000, 32'h00000000));
        plain_backlog.push_back(make_block(32'h00000000, 32'h00000000,
                                           32'h00000001, 32'h00000000));
        plain_backlog.push_back(make_block(32'h00000000, 32'h00000000,
                                           32'h00000000, 32'h80000000));
        plain_backlog.push_back(make_block(32'hFFFFFFFF, 32'h00000000,
                                           32'hFFFFFFFF, 32'h00000000));
        plain_backlog.push_back(make_block(32'h00000000, 32'hFFFFFFFF,
                                           32'h00000000, 32'hFFFFFFFF));
        plain_backlog.push_back(make_block(32'h01234567, 32'h89ABCDEF,
                                           32'hFEDCBA98, 32'h76543210));
        queue_zero_rotation();
        queue_random(5);
        wait_drained();

        // All-ones key, with the unused indexes written as well; they must not
        // disturb the key.
        load_key('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        plain_backlog.push_back(make_block('0, '0, '0, '0));
        plain_backlog.push_back(make_block('1, '1, '1, '1));
        queue_zero_rotation();
        queue_random(230);
        wait_drained();

        // Random key. The receiver holds off for a long stretch while the
        // sender keeps offering, so the core backs up into its input.
        load_key($urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        queue_random(250);
        hold_request++;
        wait_drained();

        // Key of distinct words: single-bit, half-word, counting, all-zero and all-one patterns.
        load_key(32'h00000001, 32'h80000000, 32'h0000FFFF, 32'hFFFF0000,
                 32'h01234567, 32'h89ABCDEF, 32'h00000000, 32'hFFFFFFFF, 1'b1);
        queue_zero_rotation();
        queue_random(250);
        wait_drained();

        // Final stretch: another random key and no idling on either side.
        load_key($urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        quiet = 1'b1;
        queue_random(290);
        wait_drained();

        $display("Checked %0d ciphertext blocks under %0d key settings,", blocks_checked,
                 key_settings);
        $display("including all-zero and all-one keys, with idle bursts and a long output hold.");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 1050 blocks, the key
    // expansions and the long hold-off).
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", cipher_pending.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: rc6_block_encrypt.f
hdl/rc6_pkg.sv
hdl/rc6_ram.sv
hdl/rc6_keysched.sv
hdl/rc6_round.sv
hdl/rc6_block_encrypt.sv
tb/testbench.sv
